>>> sv/drp_pkg.sv
// ============================================================================
// DNS response parser package
// Shared types and constants for the DNS response parser.
// ============================================================================
package drp_pkg;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_QNAME   = 7'b0000010,
        PH_QFIXED  = 7'b0000100,
        PH_ANAME   = 7'b0001000,
        PH_AFIXED  = 7'b0010000,
        PH_RDATA   = 7'b0100000,
        PH_DECIDED = 7'b1000000
    } phase_t;

    localparam logic [2:0] ST_INVALID = 3'd0;
    localparam logic [2:0] ST_FOUND   = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_RCODE   = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    localparam logic [0:0] REG_EXPECTED_ID   = 1'b0;
    localparam logic [0:0] REG_EXPECTED_TYPE = 1'b1;

    localparam logic [30:0] TTL_NONE    = 31'h7FFF_FFFF;
    localparam logic [30:0] TTL_DEFAULT = 31'd30;
    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] TYPE_AAAA   = 16'd28;
    localparam logic [15:0] CLASS_IN    = 16'd1;
    localparam logic [3:0]  RCODE_NXDOMAIN = 4'd3;

    // Per-packet state handed to the result stage on the last byte.
    typedef struct packed {
        phase_t        phase;
        logic [2:0]    decided;
        logic [16:0]   len;
        logic [15:0]   flags;
        logic [15:0]   rtype;
        logic [63:0]   addr_hi;
        logic [63:0]   addr_lo;
        logic [30:0]   min_ttl;
        logic          ptr_seen;
        logic [13:0]   max_ptr;
    } pkt_sum_t;

endpackage

>>> sv/drp_parse.sv
// ============================================================================
// DNS response parser byte engine
// Per-byte parse state update; emits a packet summary on the last byte.
// ============================================================================
module drp_parse
    import drp_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  pbyte,
    input  logic        last,
    input  logic [15:0] expected_id,
    input  logic [15:0] expected_type,
    output pkt_sum_t    sum
);

    phase_t        phase_reg, phase_next;
    logic [16:0]   pos_reg, pos_next;
    logic [15:0]   flags_reg, flags_next;
    logic [6:0]    qleft_reg, qleft_next;
    logic [6:0]    aleft_reg, aleft_next;
    logic [3:0]    fidx_reg, fidx_next;
    logic [7:0]    lleft_reg, lleft_next;
    logic [15:0]   rtype_reg, rtype_next;
    logic [15:0]   rclass_reg, rclass_next;
    logic [31:0]   rttl_reg, rttl_next;
    logic [15:0]   rdleft_reg, rdleft_next;
    logic [63:0]   ash0_reg, ash0_next;
    logic [63:0]   ash1_reg, ash1_next;
    logic [30:0]   minttl_reg, minttl_next;
    logic [13:0]   maxptr_reg, maxptr_next;
    logic          pseen_reg, pseen_next;
    logic [5:0]    phigh_reg, phigh_next;
    logic [2:0]    dec_reg, dec_next;
    logic          want_reg, want_next;

    logic [13:0]   ptr;
    logic          name_done;
    logic [3:0]    fidx_inc;
    logic [15:0]   rd_dec;
    logic [30:0]   ttl_sat;
    logic [6:0]    a_dec;
    logic [6:0]    q_dec;
    logic [15:0]   qcnt;
    logic [15:0]   acnt;

    assign ptr      = {phigh_reg, pbyte};
    assign fidx_inc = fidx_reg + 4'd1;
    assign rd_dec   = rdleft_reg - 16'd1;
    assign ttl_sat  = rttl_reg[31] ? TTL_NONE : rttl_reg[30:0];
    assign a_dec    = aleft_reg - 7'd1;
    assign q_dec    = qleft_reg - 7'd1;
    assign qcnt     = {rclass_reg[7:0], pbyte};
    assign acnt     = {rdleft_reg[7:0], pbyte};

    // Next-state logic for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        qleft_next  = qleft_reg;
        aleft_next  = aleft_reg;
        fidx_next   = fidx_reg;
        lleft_next  = lleft_reg;
        rtype_next  = rtype_reg;
        rclass_next = rclass_reg;
        rttl_next   = rttl_reg;
        rdleft_next = rdleft_reg;
        ash0_next   = ash0_reg;
        ash1_next   = ash1_reg;
        minttl_next = minttl_reg;
        maxptr_next = maxptr_reg;
        pseen_next  = pseen_reg;
        phigh_next  = phigh_reg;
        dec_next    = dec_reg;
        want_next   = want_reg;
        name_done   = 1'b0;
        pos_next    = (pos_reg == 17'h1FFFF) ? pos_reg : pos_reg + 17'd1;

        // Shared name skipper for question and answer names.
        if (phase_reg == PH_QNAME || phase_reg == PH_ANAME)
        begin
            if (fidx_reg == 4'd1)
            begin
                if (!pseen_reg || ptr > maxptr_reg)
                    maxptr_next = ptr;
                pseen_next = 1'b1;
                fidx_next  = 4'd0;
                name_done  = 1'b1;
            end
            else if (lleft_reg != 8'd0)
                lleft_next = lleft_reg - 8'd1;
            else if (pbyte == 8'd0)
                name_done = 1'b1;
            else if (pbyte[7:6] == 2'b11)
            begin
                phigh_next = pbyte[5:0];
                fidx_next  = 4'd1;
            end
            else
                lleft_next = pbyte;
        end

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == 17'd0 || pos_reg == 17'd1)
                    rtype_next = {rtype_reg[7:0], pbyte};
                if (pos_reg == 17'd2 || pos_reg == 17'd3)
                    flags_next = {flags_reg[7:0], pbyte};
                if (pos_reg == 17'd4 || pos_reg == 17'd5)
                    rclass_next = qcnt;
                if (pos_reg == 17'd6 || pos_reg == 17'd7)
                    rdleft_next = acnt;
                if (pos_reg == 17'd11)
                begin
                    if (rtype_reg != expected_id || !flags_reg[15]
                        || flags_reg[14:11] != 4'd0)
                    begin
                        dec_next   = ST_INVALID;
                        phase_next = PH_DECIDED;
                    end
                    else if (flags_reg[3:0] != 4'd0)
                    begin
                        dec_next   = ST_RCODE;
                        phase_next = PH_DECIDED;
                    end
                    else if (rclass_reg > 16'(MAX_RECORDS)
                             || rdleft_reg > 16'(MAX_RECORDS))
                    begin
                        dec_next   = ST_INVALID;
                        phase_next = PH_DECIDED;
                    end
                    else
                    begin
                        qleft_next  = rclass_reg[6:0];
                        aleft_next  = rdleft_reg[6:0];
                        rtype_next  = 16'd0;
                        rclass_next = 16'd0;
                        rdleft_next = 16'd0;
                        fidx_next   = 4'd0;
                        lleft_next  = 8'd0;
                        if (rclass_reg[6:0] != 7'd0)
                            phase_next = PH_QNAME;
                        else if (rdleft_reg[6:0] == 7'd0)
                        begin
                            dec_next   = ST_NONE;
                            phase_next = PH_DECIDED;
                        end
                        else
                            phase_next = PH_ANAME;
                    end
                end
            end
            PH_QNAME:
            begin
                if (name_done)
                begin
                    phase_next = PH_QFIXED;
                    fidx_next  = 4'd0;
                end
            end
            PH_QFIXED:
            begin
                fidx_next = fidx_inc;
                if (fidx_inc >= 4'd4)
                begin
                    qleft_next = q_dec;
                    fidx_next  = 4'd0;
                    lleft_next = 8'd0;
                    if (q_dec != 7'd0)
                        phase_next = PH_QNAME;
                    else if (aleft_reg == 7'd0)
                    begin
                        dec_next   = ST_NONE;
                        phase_next = PH_DECIDED;
                    end
                    else
                        phase_next = PH_ANAME;
                end
            end
            PH_ANAME:
            begin
                if (name_done)
                begin
                    phase_next = PH_AFIXED;
                    fidx_next  = 4'd0;
                end
            end
            PH_AFIXED:
            begin
                if (fidx_reg < 4'd2)
                    rtype_next = {rtype_reg[7:0], pbyte};
                else if (fidx_reg < 4'd4)
                    rclass_next = {rclass_reg[7:0], pbyte};
                else if (fidx_reg < 4'd8)
                    rttl_next = {rttl_reg[23:0], pbyte};
                else
                    rdleft_next = {rdleft_reg[7:0], pbyte};
                fidx_next = fidx_inc;
                if (fidx_inc >= 4'd10)
                begin
                    // Fixed fields complete: rdleft_next holds the length.
                    fidx_next = 4'd0;
                    if (ttl_sat < minttl_reg)
                        minttl_next = ttl_sat;
                    want_next = rclass_reg == CLASS_IN && rtype_reg == expected_type
                        && ((rtype_reg == TYPE_A && rdleft_next == 16'd4)
                            || (rtype_reg == TYPE_AAAA && rdleft_next == 16'd16));
                    ash0_next = 64'd0;
                    ash1_next = 64'd0;
                    if (rdleft_next != 16'd0)
                        phase_next = PH_RDATA;
                    else
                    begin
                        aleft_next = a_dec;
                        if (a_dec == 7'd0)
                        begin
                            dec_next   = ST_NONE;
                            phase_next = PH_DECIDED;
                        end
                        else
                        begin
                            phase_next = PH_ANAME;
                            lleft_next = 8'd0;
                        end
                    end
                end
            end
            PH_RDATA:
            begin
                ash0_next   = {ash0_reg[55:0], ash1_reg[63:56]};
                ash1_next   = {ash1_reg[55:0], pbyte};
                rdleft_next = rd_dec;
                if (rd_dec == 16'd0)
                begin
                    if (want_reg)
                    begin
                        dec_next   = ST_FOUND;
                        phase_next = PH_DECIDED;
                    end
                    else
                    begin
                        aleft_next = a_dec;
                        if (a_dec == 7'd0)
                        begin
                            dec_next   = ST_NONE;
                            phase_next = PH_DECIDED;
                        end
                        else
                        begin
                            phase_next = PH_ANAME;
                            fidx_next  = 4'd0;
                            lleft_next = 8'd0;
                        end
                    end
                end
            end
            PH_DECIDED:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Summary of the packet as it stands after this byte.
    always_comb
    begin
        sum.phase    = phase_next;
        sum.decided  = dec_next;
        sum.len      = pos_next;
        sum.flags    = flags_next;
        sum.rtype    = rtype_next;
        sum.addr_hi  = ash0_next;
        sum.addr_lo  = ash1_next;
        sum.min_ttl  = minttl_next;
        sum.ptr_seen = pseen_next;
        sum.max_ptr  = maxptr_next;
    end

    // State registers; every packet starts afresh after its last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 17'd0;
            flags_reg  <= 16'd0;
            qleft_reg  <= 7'd0;
            aleft_reg  <= 7'd0;
            fidx_reg   <= 4'd0;
            lleft_reg  <= 8'd0;
            rtype_reg  <= 16'd0;
            rclass_reg <= 16'd0;
            rttl_reg   <= 32'd0;
            rdleft_reg <= 16'd0;
            ash0_reg   <= 64'd0;
            ash1_reg   <= 64'd0;
            minttl_reg <= TTL_NONE;
            maxptr_reg <= 14'd0;
            pseen_reg  <= 1'b0;
            phigh_reg  <= 6'd0;
            dec_reg    <= ST_INVALID;
            want_reg   <= 1'b0;
        end
        else if (step && last)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 17'd0;
            flags_reg  <= 16'd0;
            qleft_reg  <= 7'd0;
            aleft_reg  <= 7'd0;
            fidx_reg   <= 4'd0;
            lleft_reg  <= 8'd0;
            rtype_reg  <= 16'd0;
            rclass_reg <= 16'd0;
            rttl_reg   <= 32'd0;
            rdleft_reg <= 16'd0;
            ash0_reg   <= 64'd0;
            ash1_reg   <= 64'd0;
            minttl_reg <= TTL_NONE;
            maxptr_reg <= 14'd0;
            pseen_reg  <= 1'b0;
            phigh_reg  <= 6'd0;
            dec_reg    <= ST_INVALID;
            want_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
            qleft_reg  <= qleft_next;
            aleft_reg  <= aleft_next;
            fidx_reg   <= fidx_next;
            lleft_reg  <= lleft_next;
            rtype_reg  <= rtype_next;
            rclass_reg <= rclass_next;
            rttl_reg   <= rttl_next;
            rdleft_reg <= rdleft_next;
            ash0_reg   <= ash0_next;
            ash1_reg   <= ash1_next;
            minttl_reg <= minttl_next;
            maxptr_reg <= maxptr_next;
            pseen_reg  <= pseen_next;
            phigh_reg  <= phigh_next;
            dec_reg    <= dec_next;
            want_reg   <= want_next;
        end
    end

endmodule

>>> sv/drp_result.sv
// ============================================================================
// DNS response parser result stage
// Turns the packet summary into the status word and holds it for output.
// ============================================================================
module drp_result
    import drp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         take,
    input  pkt_sum_t     sum,
    output logic         valid,
    output logic [167:0] word
);

    logic         valid_reg, valid_next;
    logic [167:0] word_reg;
    logic [2:0]   st;
    logic         tc;
    logic [63:0]  a_hi;
    logic [63:0]  a_lo;
    logic         v6;
    logic [30:0]  ttl;
    logic         tflag;
    logic         cach;

    assign tc = sum.flags[9];

    // Final status decision.
    always_comb
    begin
        priority if (sum.len > 17'd65535)
            st = ST_INVALID;
        else if (sum.phase == PH_DECIDED
                 && (sum.decided == ST_INVALID || sum.decided == ST_RCODE))
            st = sum.decided;
        else if (sum.phase == PH_HEADER)
            st = ST_INVALID;
        else if ((sum.ptr_seen && {3'd0, sum.max_ptr} >= sum.len)
                 || sum.phase != PH_DECIDED)
            st = tc ? ST_TRUNC : ST_INVALID;
        else
            st = sum.decided;
    end

    // Output fields for that status.
    always_comb
    begin
        a_hi  = 64'd0;
        a_lo  = 64'd0;
        v6    = 1'b0;
        ttl   = 31'd0;
        tflag = 1'b0;
        cach  = 1'b0;
        if (st == ST_FOUND)
        begin
            if (sum.rtype == TYPE_AAAA)
            begin
                a_hi = sum.addr_hi;
                a_lo = sum.addr_lo;
                v6   = 1'b1;
            end
            else
                a_lo = {32'd0, sum.addr_lo[31:0]};
        end
        if (st == ST_FOUND || st == ST_NONE)
        begin
            ttl   = (sum.min_ttl == TTL_NONE) ? TTL_DEFAULT : sum.min_ttl;
            tflag = tc;
            cach  = 1'b1;
        end
        else if (st == ST_RCODE)
        begin
            ttl   = TTL_DEFAULT;
            tflag = tc;
            cach  = sum.flags[3:0] == RCODE_NXDOMAIN;
        end
        else if (st == ST_TRUNC)
        begin
            ttl   = TTL_DEFAULT;
            tflag = 1'b1;
            cach  = 1'b1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= {3'b000, cach, tflag, ttl, v6, a_lo, a_hi, st};
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

>>> sv/dns_response_parser_core.sv
// ============================================================================
// DNS response parser core
// Streams a DNS response byte by byte and reports one address result a packet.
// ============================================================================
// The result word is registered and becomes valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; a byte is taken every cycle unless a result
// still waits in the output register while another last byte arrives.
// Reset: rst_n clears parse state, the output valid and the registers
// (expected_id 0, expected_type 1).
module dns_response_parser_core
    import drp_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // packet_byte
    input  logic         s_axis_tlast,   // end_of_packet
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], address_high[66:3], address_low[130:67], address_is_v6[131],
    // ttl_seconds[162:132], truncated_flag[163], cacheable[164], zero fill
    output logic [167:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [15:0] exp_id_reg;
    logic [15:0] exp_type_reg;
    logic        step;
    logic        take;
    pkt_sum_t    sum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg   <= 16'd0;
            exp_type_reg <= TYPE_A;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPECTED_ID:   exp_id_reg   <= cfg_data;
                REG_EXPECTED_TYPE: exp_type_reg <= cfg_data;
                default:           exp_id_reg   <= exp_id_reg;
            endcase
        end
    end

    // Only a last byte needs room in the output register.
    assign take          = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready || !s_axis_tlast;
    assign step          = s_axis_tvalid && s_axis_tready;

    drp_parse #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .pbyte         (s_axis_tdata),
        .last          (s_axis_tlast),
        .expected_id   (exp_id_reg),
        .expected_type (exp_type_reg),
        .sum           (sum)
    );

    drp_result u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step && s_axis_tlast),
        .take  (take),
        .sum   (sum),
        .valid (m_axis_tvalid),
        .word  (m_axis_tdata)
    );

    // A result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(step && s_axis_tlast))
        else $error("result overwritten");

    // A last byte produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && s_axis_tlast) |=> m_axis_tvalid)
        else $error("missing result");

    // Address fields are zero unless an address was found; the check covers the address_is_v6 flag only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] != ST_FOUND) |-> !m_axis_tdata[131])
        else $error("address flag without address");

endmodule
